// File: src/nru_pkg.sv
// ----------------------------------------------------------------------------
// nru_pkg: shared types and constants of the NRU set-associative cache
// Holds the request and result transaction layouts, configuration register
// indexes, the back-end state encoding and the set-index limit function.
// ----------------------------------------------------------------------------
package nru_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W         = 32;
    localparam int TAG_W          = 32;
    localparam int SET_W          = 6;
    localparam int WAY_OUT_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int CFG_INDEX_W    = 2;

    // Address bits that take part in the split
    localparam int ADDR_BITS      = 32;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // Range limits of the configuration registers
    localparam logic [3:0] MAX_OFFSET_BITS = 4'd12;
    localparam int         MAX_INDEX_BITS  = 6;

    // Configuration register reset values
    localparam logic [3:0] OFFSET_BITS_RESET = 4'd6;
    localparam logic [2:0] INDEX_BITS_RESET  = 3'd6;
    localparam logic [2:0] WAYS_IN_USE_RESET = 3'd4;

    // Default geometry
    localparam int DEF_MAX_SETS   = 64;
    localparam int DEF_WAYS       = 4;

    // Depth of the queues between front, back and the result port
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } cfg_index_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_UPDATE
    } back_state_t;

    // Classified access, front to back
    typedef struct packed {
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
    } req_t;

    // Lookup result, back to result queue
    typedef struct packed {
        logic                 hit;
        logic [SET_W-1:0]     set_number;
        logic [WAY_OUT_W-1:0] way_number;
        logic                 evicted;
        logic [TAG_W-1:0]     evicted_tag;
    } res_t;

    // Largest index width whose set count still fits in max_sets
    function automatic int idx_limit(input int max_sets);
        int lg;
        lg = $clog2(max_sets + 1) - 1;
        return (lg > MAX_INDEX_BITS) ? MAX_INDEX_BITS : lg;
    endfunction

endpackage

// File: src/nru_fifo.sv
// ----------------------------------------------------------------------------
// nru_fifo: small register-based queue
// Decouples two stages; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module nru_fifo
    import nru_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/nru_front.sv
// ----------------------------------------------------------------------------
// nru_front: access intake and address split
// Takes access transactions, splits the address into set and tag under the
// current offset and index widths, and queues them for the back end.
// ----------------------------------------------------------------------------
module nru_front
    import nru_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [ADDR_W-1:0] access_address,
    input  logic [3:0]        offset_bits,
    input  logic [2:0]        index_bits,
    input  logic              hold,
    input  logic              req_pop,
    output req_t              req_data,
    output logic              req_empty
);

    localparam int IDX_MAX = idx_limit(MAX_SETS);

    logic [ADDR_W-1:0] addr;
    logic [3:0]        off;
    logic [2:0]        idx;
    logic [ADDR_W-1:0] shifted;
    logic [SET_W-1:0]  set_mask;
    req_t              req;
    logic              q_full;
    logic              accept;

    // Clamp the widths and split the address
    always_comb
    begin
        addr     = access_address & ADDR_MASK;
        off      = (offset_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits;
        idx      = (index_bits > 3'(IDX_MAX)) ? 3'(IDX_MAX) : index_bits;
        shifted  = addr >> off;
        set_mask = SET_W'((7'd1 << idx) - 7'd1);
        req.set_idx = SET_W'(shifted) & set_mask;
        req.tag     = TAG_W'(addr >> (5'(off) + 5'(idx)));
    end

    // Refuse transactions while the queue is full or the store is being cleared
    assign full   = q_full || hold;
    assign accept = push && !full;

    nru_fifo #(
        .WIDTH ($bits(req_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (req),
        .full    (q_full),
        .pop     (req_pop),
        .rd_data (req_data),
        .empty   (req_empty)
    );

endmodule

// File: src/nru_back.sv
// ----------------------------------------------------------------------------
// nru_back: tag lookup and NRU replacement
// Reads one set row per access, picks the hit or victim way, writes the row
// back and issues the result transaction. Clears the store after reset.
// ----------------------------------------------------------------------------
module nru_back
    import nru_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int WAYS     = DEF_WAYS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] ways_in_use,
    input  logic       req_empty,
    input  req_t       req_data,
    output logic       req_pop,
    input  logic       out_full,
    output logic       res_push,
    output res_t       res,
    output logic       clearing
);

    localparam int IDX_MAX = idx_limit(MAX_SETS);
    localparam int ROWS    = 1 << IDX_MAX;
    localparam int ROW_AW  = (IDX_MAX > 0) ? IDX_MAX : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W  = $clog2(WAYS + 1);

    typedef struct packed {
        logic [WAYS-1:0]             used;
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][TAG_W-1:0] tags;
    } row_t;

    row_t              mem [ROWS];
    row_t              row_rd_reg;
    row_t              row_new;
    req_t              req_reg;
    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ROW_AW-1:0] clr_cnt_reg;
    logic [ROW_AW-1:0] clr_cnt_next;
    logic              mem_re;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_waddr;
    row_t              mem_wdata;

    logic [4:0]        ways_ext;
    logic [WCNT_W-1:0] nways;
    logic [WAYS-1:0]   in_use;
    logic [WAYS-1:0]   hit_vec;
    logic [WAYS-1:0]   free_vec;
    logic [WAYS-1:0]   cold_vec;
    logic [WAYS-1:0]   sel_onehot;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  cold_way;
    logic [WAY_W-1:0]  way_sel;
    logic              any_hit;
    logic              any_free;

    // Clamp associativity to one through WAYS
    always_comb
    begin
        ways_ext = 5'(ways_in_use);
        if (ways_ext == 5'd0)
        begin
            nways = WCNT_W'(1);
        end
        else if (ways_ext > 5'(WAYS))
        begin
            nways = WCNT_W'(WAYS);
        end
        else
        begin
            nways = WCNT_W'(ways_ext);
        end
    end

    // Classify the ways of the set just read and pick the way to touch
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            in_use[w]  = (WCNT_W'(w) < nways);
            hit_vec[w] = row_rd_reg.valid[w] && in_use[w]
                         && (row_rd_reg.tags[w] == req_reg.tag);
        end
        free_vec = ~row_rd_reg.valid & in_use;
        cold_vec = ~row_rd_reg.used & in_use;
        any_hit  = |hit_vec;
        any_free = |free_vec;

        hit_way  = '0;
        free_way = '0;
        cold_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (free_vec[w])
            begin
                free_way = WAY_W'(w);
            end
            if (cold_vec[w])
            begin
                cold_way = WAY_W'(w);
            end
        end

        if (any_hit)
        begin
            way_sel = hit_way;
        end
        else if (any_free)
        begin
            way_sel = free_way;
        end
        else
        begin
            way_sel = cold_way;
        end
        sel_onehot = WAYS'(1) << way_sel;

        // Update the row: mark used, fill on miss, age the set when saturated
        row_new = row_rd_reg;
        if (any_hit)
        begin
            row_new.used = row_rd_reg.used | sel_onehot;
        end
        else
        begin
            row_new.tags[way_sel] = req_reg.tag;
            row_new.valid = row_rd_reg.valid | sel_onehot;
            row_new.used  = row_rd_reg.used | sel_onehot;
            if ((row_new.used & in_use) == in_use)
            begin
                row_new.used = (row_new.used & ~in_use) | sel_onehot;
            end
        end

        res.hit         = any_hit;
        res.set_number  = req_reg.set_idx;
        res.way_number  = WAY_OUT_W'(way_sel);
        res.evicted     = !any_hit && !any_free;
        res.evicted_tag = (!any_hit && !any_free) ? row_rd_reg.tags[way_sel] : '0;
    end

    // Sequence: clear rows, then read a set and write it back per access
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_pop      = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = ROW_AW'(req_reg.set_idx);
        mem_wdata    = row_new;
        res_push     = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (!req_empty && !out_full)
                begin
                    req_pop    = 1'b1;
                    mem_re     = 1'b1;
                    state_next = B_UPDATE;
                end
            end
            B_UPDATE:
            begin
                mem_we     = 1'b1;
                res_push   = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign clearing = (state_reg == B_CLEAR);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Row store with registered read, and the request under work
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            row_rd_reg <= mem[ROW_AW'(req_data.set_idx)];
            req_reg    <= req_data;
        end
    end

    // No access is taken before the store is cleared
    a_no_pop_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !req_pop
    ) else $error("request taken during clearing pass");

    // Every request taken yields a result on the next cycle
    a_pop_then_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_pop |=> res_push
    ) else $error("request taken without a result");

    // A result is only issued into a queue with room
    a_result_has_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full
    ) else $error("result pushed into a full queue");

    // Eviction only happens on a miss, and the tag is zero otherwise
    a_evict_on_miss: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_push |-> (!(res.evicted && res.hit)
                      && (res.evicted || (res.evicted_tag == '0)))
    ) else $error("inconsistent eviction report");

endmodule

// File: src/nru_set_associative_cache_top.sv
// Order: an accepted access waits in the front queue, then the back end reads its
//   set row, compares and writes it back, and pushes the result into the result queue.
//   The back end takes the next access only after the previous one is written back.
// Reset: rst_n clears control state; a clearing pass then zeroes all
//   2^min(6,log2 MAX_SETS) rows of the store (64 by default) while full stays high.
// ----------------------------------------------------------------------------
// nru_set_associative_cache_top: set-associative tag store with NRU replacement
// Front end splits access addresses, back end looks up and replaces ways, and
// a result queue returns hit, set, way and eviction information.
// ----------------------------------------------------------------------------
module nru_set_associative_cache_top
    import nru_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int WAYS     = DEF_WAYS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [ADDR_W-1:0]      access_address,
    output logic                   empty,
    input  logic                   pop,
    output logic                   hit,
    output logic [SET_W-1:0]       set_number,
    output logic [WAY_OUT_W-1:0]   way_number,
    output logic                   evicted,
    output logic [TAG_W-1:0]       evicted_tag
);

    logic [3:0] offset_bits_reg;
    logic [2:0] index_bits_reg;
    logic [2:0] ways_in_use_reg;
    logic       req_empty;
    logic       req_pop;
    req_t       req_data;
    logic       out_full;
    logic       res_push;
    res_t       res;
    res_t       res_head;
    logic       clearing;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RESET;
            index_bits_reg  <= INDEX_BITS_RESET;
            ways_in_use_reg <= WAYS_IN_USE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[3:0];
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[2:0];
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[2:0];
                default:         offset_bits_reg <= offset_bits_reg;
            endcase
        end
    end

    nru_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .access_address (access_address),
        .offset_bits    (offset_bits_reg),
        .index_bits     (index_bits_reg),
        .hold           (clearing),
        .req_pop        (req_pop),
        .req_data       (req_data),
        .req_empty      (req_empty)
    );

    nru_back #(
        .MAX_SETS (MAX_SETS),
        .WAYS     (WAYS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ways_in_use (ways_in_use_reg),
        .req_empty   (req_empty),
        .req_data    (req_data),
        .req_pop     (req_pop),
        .out_full    (out_full),
        .res_push    (res_push),
        .res         (res),
        .clearing    (clearing)
    );

    nru_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (out_full),
        .pop     (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    // Unpack the oldest result onto the ports
    assign hit         = res_head.hit;
    assign set_number  = res_head.set_number;
    assign way_number  = res_head.way_number;
    assign evicted     = res_head.evicted;
    assign evicted_tag = res_head.evicted_tag;

endmodule

// File: verif/tb_nru_set_associative_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nru_set_associative_cache_top: self-checking bench of the NRU cache
// Walks a directed table of accesses and geometry writes, then random phases
// under bursty input and stalling output. Every result transaction is checked
// field by field against a typed table entry or an in-bench tag store model.
// ----------------------------------------------------------------------------
module tb_nru_set_associative_cache_top;
    import nru_pkg::*;

    localparam int LINE_SETS    = DEF_MAX_SETS;
    localparam int LINE_WAYS    = DEF_WAYS;
    localparam int LINE_COUNT   = LINE_SETS * LINE_WAYS;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 190;
    localparam int PRESSURE_PHASE = 4;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int ROW_COUNT    = 21;

    typedef enum logic {
        ROW_ACCESS,
        ROW_GEOMETRY
    } row_kind_t;

    // One directed step: an access, or a write of all three geometry registers
    typedef struct packed {
        row_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        off_val;
        logic [3:0]        idx_val;
        logic [3:0]        ways_val;
        logic              typed;
        res_t              want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [ADDR_W-1:0]      access_address = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   hit;
    logic [SET_W-1:0]       set_number;
    logic [WAY_OUT_W-1:0]   way_number;
    logic                   evicted;
    logic [TAG_W-1:0]       evicted_tag;

    // Model state: geometry registers and line store
    logic [3:0]       offset_reg;
    logic [2:0]       index_reg;
    logic [2:0]       ways_reg;
    logic [TAG_W-1:0] line_tag   [LINE_COUNT];
    logic             line_valid [LINE_COUNT];
    logic             line_used  [LINE_COUNT];

    res_t        pending_lookups [$];
    int          mismatch_count = 0;
    bit          hold_req = 1'b0;
    logic [31:0] tag_pool [8];

    // Directed table; expected results typed in only where obvious
    stim_row_t directed_rows [ROW_COUNT] = '{
        '{ROW_ACCESS,   32'h0000_0000, 4'd0,  4'd0,  4'd0,  1'b1,
          '{1'b0, 6'd0,  2'd0, 1'b0, 32'h0}},
        '{ROW_ACCESS,   32'h0000_0000, 4'd0,  4'd0,  4'd0,  1'b1,
          '{1'b1, 6'd0,  2'd0, 1'b0, 32'h0}},
        '{ROW_ACCESS,   32'hFFFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b1,
          '{1'b0, 6'd63, 2'd0, 1'b0, 32'h0}},
        '{ROW_ACCESS,   32'h0000_1000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_2000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_3000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_1000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_2000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_0000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_3000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_5000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_GEOMETRY, 32'h0,         4'hF,  4'h7,  4'h7,  1'b0, '0},
        '{ROW_ACCESS,   32'hFFFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0000_0000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_GEOMETRY, 32'h0,         4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'hFFFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'hFFFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b1,
          '{1'b1, 6'd0,  2'd0, 1'b0, 32'h0}},
        '{ROW_ACCESS,   32'h8000_0000, 4'd0,  4'd0,  4'd0,  1'b1,
          '{1'b0, 6'd0,  2'd0, 1'b1, 32'hFFFF_FFFF}},
        '{ROW_GEOMETRY, 32'h0,         4'd12, 4'hE,  4'hC,  1'b0, '0},
        '{ROW_ACCESS,   32'hFFFF_F000, 4'd0,  4'd0,  4'd0,  1'b0, '0},
        '{ROW_ACCESS,   32'h0003_F000, 4'd0,  4'd0,  4'd0,  1'b0, '0}
    };

    nru_set_associative_cache_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .access_address (access_address),
        .empty          (empty),
        .pop            (pop),
        .hit            (hit),
        .set_number     (set_number),
        .way_number     (way_number),
        .evicted        (evicted),
        .evicted_tag    (evicted_tag)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Clamp the geometry registers to what the store supports
    function automatic void effective_geometry(output int off, output int idx,
                                               output int nways);
        off = (offset_reg > MAX_OFFSET_BITS) ? int'(MAX_OFFSET_BITS) : int'(offset_reg);
        idx = (int'(index_reg) > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(index_reg);
        while (idx > 0 && (1 << idx) > LINE_SETS)
            idx--;
        nways = int'(ways_reg);
        if (nways < 1)
            nways = 1;
        if (nways > LINE_WAYS)
            nways = LINE_WAYS;
    endfunction

    // Look up one access, apply NRU replacement, return the expected result
    function automatic res_t predict_lookup(input logic [ADDR_W-1:0] addr);
        int               off;
        int               idx;
        int               nways;
        int               base;
        int               way;
        int               w;
        logic [63:0]      wide;
        logic [SET_W-1:0] set_sel;
        logic [TAG_W-1:0] tag;
        logic             found;
        logic             picked;
        logic             all_used;
        res_t             r;
        effective_geometry(off, idx, nways);
        wide = 64'(addr);
        set_sel = SET_W'((wide >> off) & ((64'd1 << idx) - 64'd1));
        tag = TAG_W'(wide >> (off + idx));
        base = int'(set_sel) * LINE_WAYS;
        r = '0;
        r.set_number = set_sel;
        found = 1'b0;
        way = 0;
        for (w = 0; w < nways; w++)
        begin
            if (!found && line_valid[base + w] && line_tag[base + w] == tag)
            begin
                found = 1'b1;
                way = w;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            line_used[base + way] = 1'b1;
        end
        else
        begin
            // Fill the lowest invalid way, else the lowest unused, else way 0
            for (w = 0; w < nways; w++)
            begin
                if (!found && !line_valid[base + w])
                begin
                    found = 1'b1;
                    way = w;
                end
            end
            if (!found)
            begin
                picked = 1'b0;
                way = 0;
                for (w = 0; w < nways; w++)
                begin
                    if (!picked && !line_used[base + w])
                    begin
                        picked = 1'b1;
                        way = w;
                    end
                end
                r.evicted = 1'b1;
                r.evicted_tag = line_tag[base + way];
            end
            line_tag[base + way] = tag;
            line_valid[base + way] = 1'b1;
            line_used[base + way] = 1'b1;
            // Age the set once every way in use is marked used
            all_used = 1'b1;
            for (w = 0; w < nways; w++)
                if (!line_used[base + w])
                    all_used = 1'b0;
            if (all_used)
                for (w = 0; w < nways; w++)
                    if (w != way)
                        line_used[base + w] = 1'b0;
        end
        r.way_number = WAY_OUT_W'(way);
        return r;
    endfunction

    // Mostly addresses that revisit a few tags per set, the rest raw noise
    function automatic logic [ADDR_W-1:0] pick_address();
        int          off;
        int          idx;
        int          nways;
        int          kind;
        logic [31:0] set_val;
        logic [31:0] tag_val;
        logic [63:0] a;
        effective_geometry(off, idx, nways);
        kind = $urandom_range(0, 9);
        if (kind < 2)
            return $urandom;
        set_val = $urandom_range(0, (idx > 3) ? 7 : ((1 << idx) - 1));
        if (kind < 4)
            tag_val = tag_pool[$urandom_range(0, 7)];
        else
            tag_val = $urandom_range(0, nways + 1);
        a = (64'(tag_val) << (off + idx)) | (64'(set_val) << off)
            | (64'($urandom) & ((64'd1 << off) - 64'd1));
        return a[ADDR_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Offer one access, hold it until accepted, then optionally idle
    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic typed,
                               input res_t typed_res, input int gap_after);
        res_t exp_res;
        push <= 1'b1;
        access_address <= addr;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        exp_res = predict_lookup(addr);
        if (typed)
            exp_res = typed_res;
        pending_lookups.push_back(exp_res);
        if (gap_after > 0)
        begin
            push <= 1'b0;
            repeat (gap_after) @(posedge clk);
        end
    endtask

    // Drop push and wait until every lookup has come back
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three geometry registers back to back
    task automatic program_geometry(input logic [3:0] off_val, input logic [3:0] idx_val,
                                    input logic [3:0] ways_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_OFFSET_BITS;
        cfg_data <= off_val;
        @(posedge clk);
        offset_reg = off_val;
        cfg_index <= CFG_INDEX_BITS;
        cfg_data <= idx_val;
        @(posedge clk);
        index_reg = idx_val[2:0];
        cfg_index <= CFG_WAYS_IN_USE;
        cfg_data <= ways_val;
        @(posedge clk);
        ways_reg = ways_val[2:0];
        cfg_write <= 1'b0;
    endtask

    // Result side: check each popped transaction, then pick the next pop
    initial
    begin : result_sink
        int          mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        logic [15:0] pattern;
        logic        next_pop;
        res_t        want;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        pattern = '1;
        forever
        begin
            @(posedge clk);
            if (pop === 1'b1 && empty === 1'b0)
            begin
                if (pending_lookups.size() == 0)
                    report_mismatch("result transaction with nothing pending");
                else
                begin
                    want = pending_lookups.pop_front();
                    compare_field("hit", 32'(hit), 32'(want.hit));
                    compare_field("set_number", 32'(set_number), 32'(want.set_number));
                    compare_field("way_number", 32'(way_number), 32'(want.way_number));
                    compare_field("evicted", 32'(evicted), 32'(want.evicted));
                    compare_field("evicted_tag", evicted_tag, want.evicted_tag);
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                    pattern = 16'($urandom);
                end
                mode_left--;
                case (mode)
                    0:       next_pop = 1'b1;
                    1:       next_pop = pattern[tick % 16];
                    default: next_pop = ($urandom_range(0, 3) != 0);
                endcase
                tick++;
            end
            pop <= next_pop;
        end
    end

    // Stimulus: reset, directed table, random phases, drain, verdict
    initial
    begin : stimulus
        int  i;
        int  phase;
        int  n;
        int  burst_left;
        int  gap;
        bit  steady;
        for (i = 0; i < LINE_COUNT; i++)
        begin
            line_tag[i] = '0;
            line_valid[i] = 1'b0;
            line_used[i] = 1'b0;
        end
        offset_reg = OFFSET_BITS_RESET;
        index_reg = INDEX_BITS_RESET;
        ways_reg = WAYS_IN_USE_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Hold off until the clearing pass is over
        while (full !== 1'b0)
            @(posedge clk);

        for (i = 0; i < ROW_COUNT; i++)
        begin
            if (directed_rows[i].kind == ROW_GEOMETRY)
            begin
                wait_idle();
                program_geometry(directed_rows[i].off_val, directed_rows[i].idx_val,
                                 directed_rows[i].ways_val);
            end
            else
                send_access(directed_rows[i].addr, directed_rows[i].typed,
                            directed_rows[i].want, $urandom_range(0, 2));
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       program_geometry(4'd0, 4'd0, 4'd1);
                1:       program_geometry(4'hF, 4'h7, 4'h7);
                2:       program_geometry(4'd12, 4'd6, 4'd4);
                3:       program_geometry(4'd6, 4'd2, 4'd2);
                default: program_geometry(4'($urandom), 4'($urandom), 4'($urandom));
            endcase
            for (i = 0; i < 8; i++)
                tag_pool[i] = $urandom;
            steady = (phase == PRESSURE_PHASE) || (phase == 7);
            if (phase == PRESSURE_PHASE)
                hold_req = 1'b1;
            burst_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 16);
                burst_left--;
                gap = (burst_left == 0 && !steady) ? $urandom_range(1, 8) : 0;
                send_access(pick_address(), 1'b0, '0, gap);
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/nru_pkg.sv
src/nru_fifo.sv
src/nru_front.sv
src/nru_back.sv
src/nru_set_associative_cache_top.sv
verif/tb_nru_set_associative_cache_top.sv
